/* sv/at_rlp_pkg.sv */
// shared types, constants and code points for the at response line parser
`default_nettype none
package at_rlp_pkg;

   // line store geometry
   localparam int LINE_MAX = 64;
   localparam int ADDR_W   = $clog2(LINE_MAX);
   localparam int LEN_W    = $clog2(LINE_MAX + 1);

   // special bytes
   localparam logic [7:0] BYTE_CR    = 8'd13;
   localparam logic [7:0] BYTE_LF    = 8'd10;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_K     = 8'h4B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // fixed positions inside a line
   localparam int IPD_LEN    = 7;
   localparam int CLOSED_LEN = 8;
   localparam int OK_LEN     = 2;
   localparam int POS_I      = 10;
   localparam int POS_P      = 11;
   localparam int POS_IP     = 12;
   localparam int POS_CMD    = 7;

   // prefix texts "+IPD,0," and "1,CLOSED"
   localparam logic [7:0] IPD_TEXT [IPD_LEN] =
      '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C, 8'h30, 8'h2C};
   localparam logic [7:0] CLOSED_TEXT [CLOSED_LEN] =
      '{8'h31, 8'h2C, 8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h44};

   // line event codes
   localparam logic [2:0] EV_OTHER     = 3'd0;
   localparam logic [2:0] EV_RELAY_ON  = 3'd1;
   localparam logic [2:0] EV_RELAY_OFF = 3'd2;
   localparam logic [2:0] EV_NEW_NET   = 3'd3;
   localparam logic [2:0] EV_PEER_IP   = 3'd4;
   localparam logic [2:0] EV_OK        = 3'd5;
   localparam logic [2:0] EV_CLOSED    = 3'd6;

   // one byte read back from the line store
   typedef struct packed {
      logic              vld;
      logic [ADDR_W-1:0] pos;
      logic [7:0]        data;
   } scan_beat_type;

   // classification of a finished line
   typedef struct packed {
      logic [2:0] line_event;
      logic       relay_level;
      logic [7:0] ip_octet_a;
      logic [7:0] ip_octet_b;
      logic [7:0] ip_octet_c;
      logic [7:0] ip_octet_d;
      logic [7:0] command_char;
   } verdict_type;

endpackage
`default_nettype wire

/* sv/at_rlp_ram.sv */
// generic single write port, single registered read port ram
`default_nettype none
module at_rlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/at_rlp_scan.sv */
// per byte line classifier: prefix match, ip octet parse and command pick
`default_nettype none
module at_rlp_scan
   import at_rlp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             start,
   input  wire scan_beat_type    beat,
   input  wire logic [LEN_W-1:0] line_len,
   input  wire logic             relay_cur,
   output verdict_type           verdict
);

   logic       ipd_m_ff, ipd_m_in;
   logic       ok_m_ff, ok_m_in;
   logic       cl_m_ff, cl_m_in;
   logic       at_i_ff, at_i_in;
   logic       at_p_ff, at_p_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] oct_ff [4];
   logic [7:0] oct_in [4];
   logic       colon_ff, colon_in;
   logic       take_ff, take_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] oct_cur;
   logic [7:0] oct_next;
   logic       is_ipd, is_ip, is_cmd;

   // current octet times ten plus digit, 8-bit wrap
   assign oct_cur  = oct_ff[idx_ff[1:0]];
   assign oct_next = {oct_cur[4:0], 3'b000} + {oct_cur[6:0], 1'b0} + (beat.data - CHAR_ZERO);

   // per byte update of the match flags and parsers
   always_comb begin
      ipd_m_in = ipd_m_ff;
      ok_m_in  = ok_m_ff;
      cl_m_in  = cl_m_ff;
      at_i_in  = at_i_ff;
      at_p_in  = at_p_ff;
      idx_in   = idx_ff;
      oct_in   = oct_ff;
      colon_in = colon_ff;
      take_in  = take_ff;
      cmd_in   = cmd_ff;
      if (start) begin
         ipd_m_in = 1'b1;
         ok_m_in  = 1'b1;
         cl_m_in  = 1'b1;
         at_i_in  = 1'b0;
         at_p_in  = 1'b0;
         idx_in   = 3'd0;
         oct_in   = '{8'd0, 8'd0, 8'd0, 8'd0};
         colon_in = 1'b0;
         take_in  = 1'b0;
         cmd_in   = 8'd0;
      end else if (beat.vld) begin
         // prefixes
         if (beat.pos < ADDR_W'(IPD_LEN) && beat.data != IPD_TEXT[beat.pos[2:0]]) begin
            ipd_m_in = 1'b0;
         end
         if (beat.pos < ADDR_W'(CLOSED_LEN) && beat.data != CLOSED_TEXT[beat.pos[2:0]]) begin
            cl_m_in = 1'b0;
         end
         if (beat.pos == ADDR_W'(0) && beat.data != CHAR_O) begin
            ok_m_in = 1'b0;
         end
         if (beat.pos == ADDR_W'(1) && beat.data != CHAR_K) begin
            ok_m_in = 1'b0;
         end
         // ip marker
         if (beat.pos == ADDR_W'(POS_I) && beat.data == CHAR_I) begin
            at_i_in = 1'b1;
         end
         if (beat.pos == ADDR_W'(POS_P) && beat.data == CHAR_P) begin
            at_p_in = 1'b1;
         end
         // dotted decimal octets
         if (beat.pos >= ADDR_W'(POS_IP)) begin
            if (beat.data == CHAR_DOT) begin
               if (idx_ff < 3'd4) begin
                  idx_in = idx_ff + 3'd1;
               end
            end else if (idx_ff < 3'd4) begin
               oct_in[idx_ff[1:0]] = oct_next;
            end
         end
         // byte after the first colon
         if (take_ff) begin
            cmd_in  = beat.data;
            take_in = 1'b0;
         end else if (!colon_ff && beat.pos >= ADDR_W'(POS_CMD) && beat.data == CHAR_COLON) begin
            colon_in = 1'b1;
            take_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ipd_m_ff <= ipd_m_in;
      ok_m_ff  <= ok_m_in;
      cl_m_ff  <= cl_m_in;
      at_i_ff  <= at_i_in;
      at_p_ff  <= at_p_in;
      idx_ff   <= idx_in;
      oct_ff   <= oct_in;
      colon_ff <= colon_in;
      take_ff  <= take_in;
      cmd_ff   <= cmd_in;
   end

   // final classification
   assign is_ipd = ipd_m_ff && line_len >= LEN_W'(IPD_LEN);
   assign is_ip  = is_ipd && line_len >= LEN_W'(POS_IP) && at_i_ff && at_p_ff;
   assign is_cmd = is_ipd && !is_ip;

   always_comb begin
      verdict              = '0;
      verdict.relay_level  = relay_cur;
      if (is_ip) begin
         verdict.line_event = EV_PEER_IP;
         verdict.ip_octet_a = oct_ff[0];
         verdict.ip_octet_b = oct_ff[1];
         verdict.ip_octet_c = oct_ff[2];
         verdict.ip_octet_d = oct_ff[3];
      end else if (is_cmd) begin
         verdict.command_char = cmd_ff;
         if (cmd_ff == CHAR_A) begin
            verdict.line_event  = EV_RELAY_ON;
            verdict.relay_level = 1'b1;
         end else if (cmd_ff == CHAR_B) begin
            verdict.line_event  = EV_RELAY_OFF;
            verdict.relay_level = 1'b0;
         end else if (cmd_ff == CHAR_C) begin
            verdict.line_event = EV_NEW_NET;
         end else begin
            verdict.line_event = EV_OTHER;
         end
      end else if (ok_m_ff && line_len >= LEN_W'(OK_LEN)) begin
         verdict.line_event = EV_OK;
      end else if (cl_m_ff && line_len >= LEN_W'(CLOSED_LEN)) begin
         verdict.line_event = EV_CLOSED;
      end else begin
         verdict.line_event = EV_OTHER;
      end
   end

endmodule
`default_nettype wire

/* sv/at_response_line_parser.sv */
// top level: byte intake, line store, scan sequencer and response register
`default_nettype none
// Takes received serial bytes, one request per byte, and gives one response
// per carriage return that classifies the line (relay on/off, new network,
// peer ip with parsed octets, ok, closed or other). A line feed is dropped
// and an ordinary byte is stored in the line store (64 bytes; later bytes are
// dropped and flagged as overflow). At a carriage return the stored line is
// read back through the single read port of the line store, one byte per
// cycle. The response is loaded in the done state, reached through the scan
// and drain states (an empty line goes straight to done), and no request is
// taken during that scan. The response register lets new bytes be taken while
// a response waits; a following carriage return waits for the response
// register to empty.
module at_response_line_parser
   import at_rlp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_line_event,
   output logic            rsp_relay_level,
   output logic [7:0]      rsp_ip_octet_a,
   output logic [7:0]      rsp_ip_octet_b,
   output logic [7:0]      rsp_ip_octet_c,
   output logic [7:0]      rsp_ip_octet_d,
   output logic [7:0]      rsp_command_char,
   output logic            rsp_overflowed
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              relay_ff, relay_in;
   logic [LEN_W-1:0]  ptr_ff, ptr_in;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] rd_pos_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   verdict_type       rsp_ff;
   logic              rsp_ovf_ff;

   logic              req_take;
   logic              is_cr, is_lf;
   logic              wr_en;
   logic              rd_en;
   logic [7:0]        rd_data;
   logic              start;
   logic              rsp_load;
   scan_beat_type     beat;
   verdict_type       verdict;

   // request intake
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign is_cr     = (req_rx_byte == BYTE_CR);
   assign is_lf     = (req_rx_byte == BYTE_LF);
   assign wr_en     = req_take && !is_cr && !is_lf && len_ff < LEN_W'(LINE_MAX);
   assign start     = req_take && is_cr;

   // scan reads
   assign rd_en    = (state_ff == ST_SCAN);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   at_rlp_ram #(
      .WIDTH (8),
      .DEPTH (LINE_MAX)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign beat.vld  = rd_vld_ff;
   assign beat.pos  = rd_pos_ff;
   assign beat.data = rd_data;

   at_rlp_scan u_scan (
      .clock     (clock),
      .start     (start),
      .beat      (beat),
      .line_len  (len_ff),
      .relay_cur (relay_ff),
      .verdict   (verdict)
   );

   // sequencer and line bookkeeping
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      relay_in     = relay_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && !is_lf) begin
               if (is_cr) begin
                  ptr_in   = '0;
                  state_in = (len_ff == '0) ? ST_DONE : ST_SCAN;
               end else if (len_ff < LEN_W'(LINE_MAX)) begin
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            ptr_in = ptr_ff + LEN_W'(1);
            if (ptr_ff + LEN_W'(1) == len_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               relay_in     = verdict.relay_level;
               len_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         relay_ff     <= 1'b0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         relay_ff     <= relay_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // read position follows the read data
   always_ff @(posedge clock) begin
      rd_pos_ff <= ptr_ff[ADDR_W-1:0];
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff     <= verdict;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_event   = rsp_ff.line_event;
   assign rsp_relay_level  = rsp_ff.relay_level;
   assign rsp_ip_octet_a   = rsp_ff.ip_octet_a;
   assign rsp_ip_octet_b   = rsp_ff.ip_octet_b;
   assign rsp_ip_octet_c   = rsp_ff.ip_octet_c;
   assign rsp_ip_octet_d   = rsp_ff.ip_octet_d;
   assign rsp_command_char = rsp_ff.command_char;
   assign rsp_overflowed   = rsp_ovf_ff;

   // scan never reads past the stored line
   a_scan_in_line: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> ptr_ff < len_ff)
      else $error("scan pointer beyond line length");

   // line length stays within the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_MAX))
      else $error("line length beyond store size");

   // a response is only loaded at the end of a scan
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside line end");

   // line bookkeeping restarts after a response is loaded
   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> len_ff == '0 && !ovf_ff && state_ff == ST_IDLE)
      else $error("line state not cleared after response");

endmodule
`default_nettype wire

/* sim/line_report_checker.sv */
// checker for the at response line parser: predicts line reports and compares responses
`timescale 1ns / 1ps
module line_report_checker
   import at_rlp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [2:0] rsp_line_event,
   input  wire logic       rsp_relay_level,
   input  wire logic [7:0] rsp_ip_octet_a,
   input  wire logic [7:0] rsp_ip_octet_b,
   input  wire logic [7:0] rsp_ip_octet_c,
   input  wire logic [7:0] rsp_ip_octet_d,
   input  wire logic [7:0] rsp_command_char,
   input  wire logic       rsp_overflowed,
   output int              mismatches,
   output int              open_lines
);

   // one classified line as the block should report it
   typedef struct packed {
      logic [2:0] line_event;
      logic       relay_level;
      logic [7:0] octet_a;
      logic [7:0] octet_b;
      logic [7:0] octet_c;
      logic [7:0] octet_d;
      logic [7:0] command_char;
      logic       overflowed;
   } line_report_type;

   // shadow copy of the line buffer and relay
   logic [7:0]      line_buf [LINE_MAX];
   int              line_len = 0;
   logic            drop_mark = 1'b0;
   logic            relay_bit = 1'b0;
   line_report_type pending_reports [$];
   int              fail_total = 0;
   int              report_count = 0;

   assign mismatches = fail_total;
   assign open_lines = report_count;

   // true when the buffered line starts with the given text
   function automatic bit line_starts_with(input logic [7:0] text [], input int n);
      bit hit;
      hit = (line_len >= n);
      for (int i = 0; i < n; i++) begin
         if (hit && line_buf[i] != text[i]) hit = 1'b0;
      end
      return hit;
   endfunction

   // classify the finished line, updating the relay on command lines
   function automatic line_report_type classify_line();
      line_report_type rep;
      logic [7:0]      octs [4];
      logic [7:0]      ipd_ref [];
      logic [7:0]      closed_ref [];
      logic [7:0]      c;
      int              idx;
      bit              found;
      rep = '0;
      ipd_ref = new[IPD_LEN];
      closed_ref = new[CLOSED_LEN];
      for (int i = 0; i < IPD_LEN; i++) ipd_ref[i] = IPD_TEXT[i];
      for (int i = 0; i < CLOSED_LEN; i++) closed_ref[i] = CLOSED_TEXT[i];
      if (line_starts_with(ipd_ref, IPD_LEN)) begin
         if (line_len >= POS_IP && line_buf[POS_I] == CHAR_I && line_buf[POS_P] == CHAR_P) begin
            // dotted decimal with 8-bit wrap, extra octets ignored
            for (int k = 0; k < 4; k++) octs[k] = 8'd0;
            idx = 0;
            for (int i = POS_IP; i < line_len; i++) begin
               c = line_buf[i];
               if (c == CHAR_DOT) begin
                  if (idx < 4) idx++;
               end else if (idx < 4) begin
                  octs[idx] = 8'(octs[idx] * 10 + c - CHAR_ZERO);
               end
            end
            rep.line_event = EV_PEER_IP;
            rep.octet_a = octs[0];
            rep.octet_b = octs[1];
            rep.octet_c = octs[2];
            rep.octet_d = octs[3];
         end else begin
            // character after the first colon from the command position on
            found = 1'b0;
            for (int i = POS_CMD; i < line_len; i++) begin
               if (!found && line_buf[i] == CHAR_COLON) begin
                  found = 1'b1;
                  if (i + 1 < line_len) rep.command_char = line_buf[i + 1];
               end
            end
            case (rep.command_char)
               CHAR_A: begin
                  relay_bit = 1'b1;
                  rep.line_event = EV_RELAY_ON;
               end
               CHAR_B: begin
                  relay_bit = 1'b0;
                  rep.line_event = EV_RELAY_OFF;
               end
               CHAR_C: rep.line_event = EV_NEW_NET;
               default: rep.line_event = EV_OTHER;
            endcase
         end
      end else if (line_len >= OK_LEN && line_buf[0] == CHAR_O && line_buf[1] == CHAR_K) begin
         rep.line_event = EV_OK;
      end else if (line_starts_with(closed_ref, CLOSED_LEN)) begin
         rep.line_event = EV_CLOSED;
      end else begin
         rep.line_event = EV_OTHER;
      end
      rep.relay_level = relay_bit;
      rep.overflowed = drop_mark;
      return rep;
   endfunction

   // take one accepted byte into the shadow line
   task automatic take_byte(input logic [7:0] b);
      if (b == BYTE_LF) begin
         // line feeds never reach the buffer
      end else if (b != BYTE_CR) begin
         if (line_len < LINE_MAX) begin
            line_buf[line_len] = b;
            line_len++;
         end else begin
            drop_mark = 1'b1;
         end
      end else begin
         pending_reports.push_back(classify_line());
         line_len = 0;
         drop_mark = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_total++;
      end
   endtask

   // responses are matched before the same edge's request is predicted
   always @(posedge clock) begin
      line_report_type want;
      if (reset) begin
         line_len = 0;
         drop_mark = 1'b0;
         relay_bit = 1'b0;
         pending_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("response with no line pending: event %0d", rsp_line_event);
               fail_total++;
            end else begin
               want = pending_reports.pop_front();
               check_field("line_event", want.line_event, rsp_line_event);
               check_field("relay_level", want.relay_level, rsp_relay_level);
               check_field("ip_octet_a", want.octet_a, rsp_ip_octet_a);
               check_field("ip_octet_b", want.octet_b, rsp_ip_octet_b);
               check_field("ip_octet_c", want.octet_c, rsp_ip_octet_c);
               check_field("ip_octet_d", want.octet_d, rsp_ip_octet_d);
               check_field("command_char", want.command_char, rsp_command_char);
               check_field("overflowed", want.overflowed, rsp_overflowed);
            end
         end
         if (req_valid && req_ready) take_byte(req_rx_byte);
      end
      report_count = pending_reports.size();
   end

endmodule

/* sim/at_response_line_parser_test.sv */
// testbench top for the at response line parser: byte stimulus, response pacing and verdict
`timescale 1ns / 1ps
module at_response_line_parser_test
   import at_rlp_pkg::*;
;

   localparam int RANDOM_BYTES = 1500;
   localparam int CALM_BYTES   = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 600000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_line_event;
   logic       rsp_relay_level;
   logic [7:0] rsp_ip_octet_a;
   logic [7:0] rsp_ip_octet_b;
   logic [7:0] rsp_ip_octet_c;
   logic [7:0] rsp_ip_octet_d;
   logic [7:0] rsp_command_char;
   logic       rsp_overflowed;

   int         mismatches;
   int         open_lines;
   int         sent_count = 0;
   int         cycle_count = 0;
   bit         idle_on = 1'b1;
   bit         hold_off_pending = 1'b0;
   logic [7:0] line_bytes [$];

   at_response_line_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_event   (rsp_line_event),
      .rsp_relay_level  (rsp_relay_level),
      .rsp_ip_octet_a   (rsp_ip_octet_a),
      .rsp_ip_octet_b   (rsp_ip_octet_b),
      .rsp_ip_octet_c   (rsp_ip_octet_c),
      .rsp_ip_octet_d   (rsp_ip_octet_d),
      .rsp_command_char (rsp_command_char),
      .rsp_overflowed   (rsp_overflowed)
   );

   line_report_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_event   (rsp_line_event),
      .rsp_relay_level  (rsp_relay_level),
      .rsp_ip_octet_a   (rsp_ip_octet_a),
      .rsp_ip_octet_b   (rsp_ip_octet_b),
      .rsp_ip_octet_c   (rsp_ip_octet_c),
      .rsp_ip_octet_d   (rsp_ip_octet_d),
      .rsp_command_char (rsp_command_char),
      .rsp_overflowed   (rsp_overflowed),
      .mismatches       (mismatches),
      .open_lines       (open_lines)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // offer one byte as a request, with an occasional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // send the assembled line, sprinkling line feeds, then the carriage return
   task automatic send_line();
      foreach (line_bytes[i]) begin
         if ($urandom_range(0, 31) == 0) send_byte(BYTE_LF);
         send_byte(line_bytes[i]);
      end
      send_byte(BYTE_CR);
      line_bytes.delete();
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(8'(s[i]));
   endtask

   task automatic send_text(input string s);
      put_text(s);
      send_line();
   endtask

   task automatic put_printable(input int n);
      repeat (n) line_bytes.push_back(8'($urandom_range(32, 126)));
   endtask

   task automatic put_digits(input int n);
      repeat (n) line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
   endtask

   // well-formed line of one kind with random content
   task automatic build_line(input int kind);
      int parts;
      case (kind)
         0: begin
            // command line
            put_text("+IPD,0,");
            put_digits($urandom_range(0, 3));
            if ($urandom_range(0, 7) != 0) begin
               line_bytes.push_back(CHAR_COLON);
               case ($urandom_range(0, 4))
                  0: line_bytes.push_back(CHAR_A);
                  1: line_bytes.push_back(CHAR_B);
                  2: line_bytes.push_back(CHAR_C);
                  3: put_printable(1);
                  default: ;
               endcase
               put_printable($urandom_range(0, 4));
            end
         end
         1: begin
            // peer ip report
            put_text("+IPD,0,");
            put_printable(3);
            put_text("IP");
            parts = $urandom_range(0, 6);
            for (int p = 0; p < parts; p++) begin
               if (p > 0) line_bytes.push_back(CHAR_DOT);
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 15) == 0) put_printable(1);
                  else put_digits(1);
               end
            end
         end
         2: begin
            put_text("OK");
            put_printable($urandom_range(0, 5));
         end
         default: begin
            put_text("1,CLOSED");
            put_printable($urandom_range(0, 5));
         end
      endcase
   endtask

   // reset and stimulus
   initial begin
      int start_count;
      int pick;
      int n;
      int idx;
      int v;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines: prefixes, length limits, commands, ip parsing
      send_text("");
      send_text("OK");
      send_text("O");
      send_text("OKAY");
      send_text("1,CLOSED");
      send_text("1,CLOSE");
      send_text("+IPD,0");
      send_text("+IPD,0,5:A");
      send_text("+IPD,0,5:C");
      send_text("+IPD,0,5:B");
      send_text("+IPD,0,5:x");
      send_text("+IPD,0,5:");
      send_text("+IPD,0,5");
      send_text("+IPD,0,:A");
      send_text("+IPD,0,12,IP192.168.4.1");
      send_text("+IPD,0,12,IP1.2.3.4.5.6");
      send_text("+IPD,0,12,IP999.256.a.");
      send_text("+IPD,0,12,IP");
      send_text("+IPD,0,12,I");
      send_text("+IPD,0,12,IQ:B");
      send_text("+IPD,1,5:A");
      send_text("O\nK");
      // byte extremes
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(8'h80);
      line_bytes.push_back(8'h7F);
      send_line();
      // line that fills the buffer exactly, then one that overflows it
      put_text("OK");
      put_printable(LINE_MAX - 2);
      send_line();
      put_text("+IPD,0,7:A");
      put_printable(LINE_MAX);
      send_line();

      // random lines, with one long response hold-off early on
      hold_off_pending = 1'b1;
      start_count = sent_count;
      while (sent_count - start_count < RANDOM_BYTES) begin
         if (sent_count - start_count > RANDOM_BYTES - CALM_BYTES) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            build_line(0);
         end else if (pick < 45) begin
            build_line(1);
         end else if (pick < 55) begin
            build_line(2);
         end else if (pick < 65) begin
            build_line(3);
         end else if (pick < 80) begin
            // near miss: one byte of a good line replaced
            build_line($urandom_range(0, 3));
            idx = $urandom_range(0, line_bytes.size() - 1);
            v = BYTE_CR;
            while (v == BYTE_CR || v == BYTE_LF) v = $urandom_range(0, 255);
            line_bytes[idx] = 8'(v);
         end else if (pick < 92) begin
            // raw noise, may hold its own line ends
            n = $urandom_range(0, 16);
            repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 96) begin
            // long line around the buffer limit
            n = $urandom_range(LINE_MAX - 4, LINE_MAX + 16);
            if ($urandom_range(0, 1) == 1) build_line(0);
            while (line_bytes.size() < n) put_printable(1);
         end else begin
            n = $urandom_range(0, 2);
            repeat (n) line_bytes.push_back($urandom_range(0, 1) ? CHAR_O : CHAR_K);
         end
         send_line();
      end
      req_valid <= 1'b0;

      // drain and verdict
      wait (open_lines == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // response side: random stall bursts plus one long hold-off
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

endmodule

/* at_response_line_parser.f */
sv/at_rlp_pkg.sv
sv/at_rlp_ram.sv
sv/at_rlp_scan.sv
sv/at_response_line_parser.sv
sim/line_report_checker.sv
sim/at_response_line_parser_test.sv
